>>> rtl/psr_pkg.sv
package psr_pkg;

    // event kinds carried in the mode field
    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_END    = 2'd2,
        MODE_OTHER  = 2'd3
    } mode_t;

    // verdict codes of one result word
    typedef enum logic [2:0] {
        VERDICT_IGNORE  = 3'd0,
        VERDICT_MAYBE   = 3'd1,
        VERDICT_TRIGGER = 3'd2,
        VERDICT_FINISH  = 3'd3,
        VERDICT_CANCEL  = 3'd4
    } verdict_t;

    localparam int MODE_W       = 2;
    localparam int COUNT_W      = 4;
    localparam int VERDICT_W    = 3;
    localparam int STEP_W       = 17;
    localparam int THRESHOLD_W  = 10;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // scale is kept in tenths: 0.7 per pixel of span change
    localparam int STEP_GAIN       = 7;
    localparam int TENTHS_PER_UNIT = 10;

    localparam logic [COUNT_W-1:0]     MIN_LIVE_POINTS = 4'd2;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 10'd20;

    // register word indexes (byte address bits above the word offset)
    localparam logic REG_THRESHOLD = 1'b0;

endpackage

>>> rtl/psr_event_if.sv
interface psr_event_if #(
    parameter int COORD_BITS = 12
);
    logic                            valid;
    logic                            ready;
    logic [psr_pkg::MODE_W-1:0]      mode;
    logic [psr_pkg::COUNT_W-1:0]     point_count;
    logic [COORD_BITS-1:0]           first_x;
    logic [COORD_BITS-1:0]           first_y;
    logic [COORD_BITS-1:0]           second_x;
    logic [COORD_BITS-1:0]           second_y;
    logic [COORD_BITS-1:0]           prev_first_x;
    logic [COORD_BITS-1:0]           prev_first_y;
    logic [COORD_BITS-1:0]           prev_second_x;
    logic [COORD_BITS-1:0]           prev_second_y;
    logic                            first_released;
    logic                            second_released;

    modport source (
        output valid, mode, point_count, first_x, first_y, second_x, second_y,
               prev_first_x, prev_first_y, prev_second_x, prev_second_y,
               first_released, second_released,
        input  ready
    );

    modport sink (
        input  valid, mode, point_count, first_x, first_y, second_x, second_y,
               prev_first_x, prev_first_y, prev_second_x, prev_second_y,
               first_released, second_released,
        output ready
    );
endinterface

>>> rtl/psr_result_if.sv
interface psr_result_if #(
    parameter int COORD_BITS = 12,
    parameter int TOTAL_BITS = 24
);
    logic                              valid;
    logic                              ready;
    logic [psr_pkg::VERDICT_W-1:0]     verdict;
    logic                              consume_hint;
    logic                              accepted;
    logic signed [psr_pkg::STEP_W-1:0] step_scale_tenths;
    logic signed [TOTAL_BITS-1:0]      total_scale_tenths;
    logic [COORD_BITS:0]               hotspot_x_doubled;
    logic [COORD_BITS:0]               hotspot_y_doubled;
    logic                              hotspot_valid;

    modport source (
        output valid, verdict, consume_hint, accepted, step_scale_tenths,
               total_scale_tenths, hotspot_x_doubled, hotspot_y_doubled,
               hotspot_valid,
        input  ready
    );

    modport sink (
        input  valid, verdict, consume_hint, accepted, step_scale_tenths,
               total_scale_tenths, hotspot_x_doubled, hotspot_y_doubled,
               hotspot_valid,
        output ready
    );
endinterface

>>> rtl/psr_step.sv
module psr_step #(
    parameter int COORD_BITS = 12,
    parameter int TOTAL_BITS = 24
) (
    input  psr_pkg::mode_t                      mode,
    input  logic [psr_pkg::COUNT_W-1:0]         point_count,
    input  logic [COORD_BITS-1:0]               first_x,
    input  logic [COORD_BITS-1:0]               first_y,
    input  logic [COORD_BITS-1:0]               second_x,
    input  logic [COORD_BITS-1:0]               second_y,
    input  logic [COORD_BITS-1:0]               prev_first_x,
    input  logic [COORD_BITS-1:0]               prev_first_y,
    input  logic [COORD_BITS-1:0]               prev_second_x,
    input  logic [COORD_BITS-1:0]               prev_second_y,
    input  logic                                first_released,
    input  logic                                second_released,
    input  logic [psr_pkg::THRESHOLD_W-1:0]     threshold,
    input  logic                                active,
    input  logic signed [TOTAL_BITS-1:0]        total,
    output psr_pkg::verdict_t                   verdict,
    output logic                                consume_hint,
    output logic                                accepted,
    output logic signed [psr_pkg::STEP_W-1:0]   step_scale_tenths,
    output logic signed [TOTAL_BITS-1:0]        total_next,
    output logic                                active_next,
    output logic [COORD_BITS:0]                 hotspot_x_doubled,
    output logic [COORD_BITS:0]                 hotspot_y_doubled,
    output logic                                hotspot_valid
);

    localparam int SW = (COORD_BITS + 5 > psr_pkg::STEP_W) ? COORD_BITS + 5 : psr_pkg::STEP_W;
    localparam int AW = ((TOTAL_BITS > SW) ? TOTAL_BITS : SW) + 1;
    localparam logic signed [AW-1:0] TMAX =
        AW'((64'd1 << (TOTAL_BITS - 1)) - 64'd1);
    localparam logic signed [AW-1:0] TMIN = -TMAX;

    logic                         two;
    logic                         released;
    logic [COORD_BITS-1:0]        hot_sx;
    logic [COORD_BITS-1:0]        hot_sy;
    logic [COORD_BITS-1:0]        span_x;
    logic [COORD_BITS-1:0]        span_y;
    logic [COORD_BITS-1:0]        span_px;
    logic [COORD_BITS-1:0]        span_py;
    logic signed [COORD_BITS+1:0] span_delta;
    logic signed [SW-1:0]         step_full;
    logic signed [AW-1:0]         total_sum;
    logic signed [TOTAL_BITS-1:0] total_sat;
    logic [TOTAL_BITS-1:0]        total_mag;
    logic [TOTAL_BITS-1:0]        trip_limit;
    logic                         over_limit;
    logic [COORD_BITS:0]          hot_x;
    logic [COORD_BITS:0]          hot_y;

    assign two      = (point_count >= psr_pkg::MIN_LIVE_POINTS);
    assign released = first_released | second_released;

    // a single-point begin uses the first point twice
    assign hot_sx = (mode == psr_pkg::MODE_BEGIN && !two) ? first_x : second_x;
    assign hot_sy = (mode == psr_pkg::MODE_BEGIN && !two) ? first_y : second_y;
    assign hot_x  = {1'b0, first_x} + {1'b0, hot_sx};
    assign hot_y  = {1'b0, first_y} + {1'b0, hot_sy};

    // horizontal and vertical spans, now and before
    assign span_x  = (second_x > first_x) ? second_x - first_x : first_x - second_x;
    assign span_y  = (second_y > first_y) ? second_y - first_y : first_y - second_y;
    assign span_px = (prev_second_x > prev_first_x) ? prev_second_x - prev_first_x
                                                    : prev_first_x - prev_second_x;
    assign span_py = (prev_second_y > prev_first_y) ? prev_second_y - prev_first_y
                                                    : prev_first_y - prev_second_y;

    assign span_delta = $signed({2'b00, span_x}) - $signed({2'b00, span_px})
                      + $signed({2'b00, span_y}) - $signed({2'b00, span_py});

    // step in tenths, 0.7 per pixel
    assign step_full = SW'(span_delta) * SW'(psr_pkg::STEP_GAIN);

    // saturating running total
    assign total_sum = AW'(total) + AW'(step_full);
    always_comb
    begin
        priority if (total_sum > TMAX)
        begin
            total_sat = TOTAL_BITS'(TMAX);
        end
        else if (total_sum < TMIN)
        begin
            total_sat = TOTAL_BITS'(TMIN);
        end
        else
        begin
            total_sat = TOTAL_BITS'(total_sum);
        end
    end

    // trunc(|total| / 10) > threshold  <=>  |total| > 10 * threshold + 9
    assign total_mag  = total_sat[TOTAL_BITS-1] ? TOTAL_BITS'(-total_sat)
                                                : TOTAL_BITS'(total_sat);
    assign trip_limit = TOTAL_BITS'(threshold) * TOTAL_BITS'(psr_pkg::TENTHS_PER_UNIT)
                      + TOTAL_BITS'(psr_pkg::TENTHS_PER_UNIT - 1);
    assign over_limit = (total_mag > trip_limit);

    // verdict and state update per event kind
    always_comb
    begin
        verdict           = psr_pkg::VERDICT_IGNORE;
        consume_hint      = 1'b0;
        accepted          = 1'b0;
        hotspot_valid     = 1'b0;
        step_scale_tenths = '0;
        total_next        = total;
        active_next       = active;
        unique case (mode)
            psr_pkg::MODE_BEGIN:
            begin
                verdict       = psr_pkg::VERDICT_MAYBE;
                consume_hint  = 1'b1;
                accepted      = 1'b1;
                hotspot_valid = 1'b1;
            end
            psr_pkg::MODE_UPDATE:
            begin
                if (!two || released)
                begin
                    verdict = active ? psr_pkg::VERDICT_FINISH : psr_pkg::VERDICT_MAYBE;
                end
                else
                begin
                    accepted          = 1'b1;
                    hotspot_valid     = 1'b1;
                    step_scale_tenths = step_full[psr_pkg::STEP_W-1:0];
                    total_next        = total_sat;
                    verdict = (active || over_limit) ? psr_pkg::VERDICT_TRIGGER
                                                     : psr_pkg::VERDICT_MAYBE;
                end
            end
            psr_pkg::MODE_END:
            begin
                verdict = active ? psr_pkg::VERDICT_FINISH : psr_pkg::VERDICT_CANCEL;
            end
            psr_pkg::MODE_OTHER:
            begin
                verdict = psr_pkg::VERDICT_IGNORE;
            end
            default:
            begin
                verdict = psr_pkg::VERDICT_IGNORE;
            end
        endcase

        if (verdict == psr_pkg::VERDICT_TRIGGER)
        begin
            active_next = 1'b1;
        end
        if (verdict == psr_pkg::VERDICT_FINISH || verdict == psr_pkg::VERDICT_CANCEL)
        begin
            active_next = 1'b0;
            total_next  = '0;
        end
    end

    assign hotspot_x_doubled = hotspot_valid ? hot_x : '0;
    assign hotspot_y_doubled = hotspot_valid ? hot_y : '0;

endmodule

>>> rtl/pinch_scale_recognizer.sv
// Pinch-scale recognizer: one touch event word in, one verdict word out. Each event is
// registered in the input register on acceptance and evaluated there against the gesture
// state (active flag and saturating scale total in tenths); its result is captured in the
// output register once that register is free or draining. A new event can be accepted
// every cycle while results are taken; a result that waits leaves room for one more event
// in the input register, after which the input stalls until the result is taken. Throughput
// is one word per cycle while results are taken, set by the single evaluate-and-update step
// that carries the total from one event to the next. The threshold register sits at byte
// address 0 of the APB port; the user must write it only while no event is in flight, as
// the block itself does not enforce it. It resets to 20.
module pinch_scale_recognizer #(
    parameter int COORD_BITS = 12,
    parameter int TOTAL_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    psr_event_if.sink                          evt,
    psr_result_if.source                       res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [psr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [psr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [psr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    // configuration
    logic [psr_pkg::THRESHOLD_W-1:0] threshold_reg;
    logic [psr_pkg::THRESHOLD_W-1:0] threshold_next;

    // gesture state
    logic                            active_reg;
    logic                            active_next;
    logic signed [TOTAL_BITS-1:0]    total_reg;
    logic signed [TOTAL_BITS-1:0]    total_next;

    // input stage
    logic                            in_valid_reg;
    logic                            in_valid_next;
    psr_pkg::mode_t                  mode_reg;
    logic [psr_pkg::COUNT_W-1:0]     count_reg;
    logic [COORD_BITS-1:0]           fx_reg;
    logic [COORD_BITS-1:0]           fy_reg;
    logic [COORD_BITS-1:0]           sx_reg;
    logic [COORD_BITS-1:0]           sy_reg;
    logic [COORD_BITS-1:0]           pfx_reg;
    logic [COORD_BITS-1:0]           pfy_reg;
    logic [COORD_BITS-1:0]           psx_reg;
    logic [COORD_BITS-1:0]           psy_reg;
    logic                            frel_reg;
    logic                            srel_reg;

    // result stage
    logic                            out_valid_reg;
    logic                            out_valid_next;
    psr_pkg::verdict_t               verdict_reg;
    logic                            consume_reg;
    logic                            accepted_reg;
    logic signed [psr_pkg::STEP_W-1:0] step_reg;
    logic signed [TOTAL_BITS-1:0]    total_out_reg;
    logic [COORD_BITS:0]             hx_reg;
    logic [COORD_BITS:0]             hy_reg;
    logic                            hvalid_reg;

    // evaluation results
    psr_pkg::verdict_t               eval_verdict;
    logic                            eval_consume;
    logic                            eval_accepted;
    logic signed [psr_pkg::STEP_W-1:0] eval_step;
    logic [COORD_BITS:0]             eval_hx;
    logic [COORD_BITS:0]             eval_hy;
    logic                            eval_hvalid;

    logic                            advance;
    logic                            take_in;
    logic                            cfg_write;

    // handshakes: the input stage moves on whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign take_in   = evt.valid && evt.ready;

    assign in_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                    && (paddr[psr_pkg::APB_ADDR_W-1] == psr_pkg::REG_THRESHOLD);
    assign threshold_next = cfg_write ? pwdata[psr_pkg::THRESHOLD_W-1:0] : threshold_reg;
    assign prdata = (paddr[psr_pkg::APB_ADDR_W-1] == psr_pkg::REG_THRESHOLD)
                  ? psr_pkg::APB_DATA_W'(threshold_reg) : '0;

    // evaluation of the registered event
    psr_step #(
        .COORD_BITS (COORD_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_step (
        .mode              (mode_reg),
        .point_count       (count_reg),
        .first_x           (fx_reg),
        .first_y           (fy_reg),
        .second_x          (sx_reg),
        .second_y          (sy_reg),
        .prev_first_x      (pfx_reg),
        .prev_first_y      (pfy_reg),
        .prev_second_x     (psx_reg),
        .prev_second_y     (psy_reg),
        .first_released    (frel_reg),
        .second_released   (srel_reg),
        .threshold         (threshold_reg),
        .active            (active_reg),
        .total             (total_reg),
        .verdict           (eval_verdict),
        .consume_hint      (eval_consume),
        .accepted          (eval_accepted),
        .step_scale_tenths (eval_step),
        .total_next        (total_next),
        .active_next       (active_next),
        .hotspot_x_doubled (eval_hx),
        .hotspot_y_doubled (eval_hy),
        .hotspot_valid     (eval_hvalid)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= psr_pkg::THRESHOLD_RESET;
            active_reg    <= 1'b0;
            total_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            threshold_reg <= threshold_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                active_reg <= active_next;
                total_reg  <= total_next;
            end
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            mode_reg  <= psr_pkg::mode_t'(evt.mode);
            count_reg <= evt.point_count;
            fx_reg    <= evt.first_x;
            fy_reg    <= evt.first_y;
            sx_reg    <= evt.second_x;
            sy_reg    <= evt.second_y;
            pfx_reg   <= evt.prev_first_x;
            pfy_reg   <= evt.prev_first_y;
            psx_reg   <= evt.prev_second_x;
            psy_reg   <= evt.prev_second_y;
            frel_reg  <= evt.first_released;
            srel_reg  <= evt.second_released;
        end
    end

    // result word capture
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg   <= eval_verdict;
            consume_reg   <= eval_consume;
            accepted_reg  <= eval_accepted;
            step_reg      <= eval_step;
            total_out_reg <= total_next;
            hx_reg        <= eval_hx;
            hy_reg        <= eval_hy;
            hvalid_reg    <= eval_hvalid;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.verdict            = verdict_reg;
    assign res.consume_hint       = consume_reg;
    assign res.accepted           = accepted_reg;
    assign res.step_scale_tenths  = step_reg;
    assign res.total_scale_tenths = total_out_reg;
    assign res.hotspot_x_doubled  = hx_reg;
    assign res.hotspot_y_doubled  = hy_reg;
    assign res.hotspot_valid      = hvalid_reg;

endmodule
